/* hw/rtl/fbs_pkg.sv */
`default_nettype none
package fbs_pkg;

	// array sizes
	localparam int FANS        = 8;
	localparam int STAVE_TYPES = 4;
	localparam int ELEMS       = 16;
	localparam int TAPS        = 32;

	// field widths fixed by the interface
	localparam int SMP_W = 16;
	localparam int SUM_W = 48;

	// memory geometry
	localparam int TAP_DEPTH  = FANS * STAVE_TYPES * ELEMS * TAPS;
	localparam int COR_DEPTH  = FANS * STAVE_TYPES * ELEMS;
	localparam int TAP_AW     = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
	localparam int COR_AW     = (COR_DEPTH > 1) ? $clog2(COR_DEPTH) : 1;
	localparam int TAP_IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int HIST_SLOTS = 2 ** TAP_IDX_W;
	localparam int ELEM_W     = (ELEMS > 1) ? $clog2(ELEMS) : 1;
	localparam int HIST_DEPTH = (2 ** ELEM_W) * HIST_SLOTS;
	localparam int HIST_AW    = ELEM_W + TAP_IDX_W;
	localparam int TAP_CNT_W  = $clog2(TAPS + 1);
	localparam int FAN_W      = (FANS > 1) ? $clog2(FANS) : 1;

	// datapath widths
	localparam int ACC_W = 2 * SMP_W + TAP_CNT_W;
	localparam int P_W   = ACC_W + SMP_W;
	localparam int T_W   = P_W + 1 - 15;

	// op codes
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TAP    = 2'd1;
	localparam logic [1:0] OP_COR    = 2'd2;

	// register indexes
	localparam logic REG_FAN_MASK = 1'b0;
	localparam logic REG_TAPS     = 1'b1;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic acc_en;
	} mac_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/fir_beamformer_stave_unit.sv */
// Filter-and-sum beamformer for one stave. Each sample beat runs, for every
// fan enabled in fan_mask, a real-tap FIR over the element's newest
// taps_in_use history samples and a complex correction multiply, then adds
// into that fan's saturating 48-bit sum; a sample beat marked last_element
// then sends one beat per enabled fan and clears the sums. Load beats write the
// tap and correction memories as they are taken. One multiply-accumulate unit does
// all the work: a sample beat walks the eight fans in turn and, for each enabled
// fan, runs the FIR (skipped with no taps, taps_in_use above 32 counts as 32)
// and the correction; a last element then sends the fan sums, waiting while
// out_ready holds a result back. in_ready stays low meanwhile. Tap and correction
// entries must be loaded before they are used; the element history reads as zero
// after reset.
`default_nettype none
module fir_beamformer_stave_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [7:0]                        cfg_data,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        op,
	input  wire logic [13:0]                       index,
	input  wire logic [3:0]                        element,
	input  wire logic [1:0]                        stave_type,
	input  wire logic                              first_sample,
	input  wire logic                              last_element,
	input  wire logic signed [15:0]                sample_re,
	input  wire logic signed [15:0]                sample_im,
	input  wire logic signed [15:0]                load_re,
	input  wire logic signed [15:0]                load_im,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [2:0]                             fan,
	output logic signed [47:0]                     out_re,
	output logic signed [47:0]                     out_im,
	output logic                                   last
);
	import fbs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FAN   = 3'd1;
	localparam logic [2:0] S_TAP   = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_COR1  = 3'd4;
	localparam logic [2:0] S_COR2  = 3'd5;
	localparam logic [2:0] S_COR3  = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	logic [2:0]             state_q;
	logic [7:0]             fan_mask_q;
	logic [5:0]             taps_q;
	logic [TAP_CNT_W-1:0]   n_q;
	logic [FAN_W-1:0]       fan_q;
	logic [TAP_IDX_W-1:0]   k_q;
	logic [ELEM_W-1:0]      elem_q;
	logic [1:0]             stype_q;
	logic                   last_q;
	logic [TAP_IDX_W-1:0]   ptr_q [ELEMS];
	logic [TAP_CNT_W-1:0]   cnt_q [ELEMS];
	logic signed [SUM_W-1:0] sum_re_q [FANS];
	logic signed [SUM_W-1:0] sum_im_q [FANS];
	logic signed [T_W-1:0]  tre_q;
	logic                   iss_s1;
	logic                   hv_s1;

	logic                   accept;
	logic                   elem_ok;
	logic [ELEM_W-1:0]      in_elem;
	logic [FANS-1:0]        fan_en;
	logic                   fan_last;
	logic [COR_AW-1:0]      cor_base;
	logic [TAP_AW-1:0]      tap_raddr;
	logic [HIST_AW-1:0]     hist_raddr;
	logic [HIST_AW-1:0]     hist_waddr;
	logic [TAP_IDX_W-1:0]   new_ptr;
	logic [SMP_W-1:0]       tap_rd;
	logic [2*SMP_W-1:0]     cor_rd;
	logic [2*SMP_W-1:0]     hist_rd;
	logic                   tap_we;
	logic                   cor_we;
	logic                   hist_we;
	logic [TAP_CNT_W-1:0]   n_next;
	logic                   out_room;
	logic                   higher_en;

	mac_ctrl_t              mac_ctrl;
	logic signed [ACC_W-1:0] mx_re, mx_im;
	logic signed [SMP_W-1:0] my_re, my_im;
	logic signed [P_W-1:0]  p_re_s1, p_im_s1;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic                   mac_busy;
	logic signed [P_W:0]    dre, dim;
	logic signed [T_W-1:0]  tim;
	logic signed [SUM_W:0]  nsum_re, nsum_im;
	logic signed [SUM_W-1:0] sat_re, sat_im;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_elem  = ELEM_W'(element);
	assign elem_ok  = (32'(element) < ELEMS);
	assign fan_en   = FANS'(fan_mask_q);
	assign fan_last = (fan_q == FAN_W'(FANS - 1));
	assign out_room = !out_valid || out_ready;
	assign n_next   = (32'(taps_q) > TAPS) ? TAP_CNT_W'(TAPS) : TAP_CNT_W'(taps_q);

	// any enabled fan above the current one
	always_comb begin
		higher_en = 1'b0;
		for (int i = 0; i < FANS; i++) begin
			if (i > 32'(fan_q) && fan_en[i]) begin
				higher_en = 1'b1;
			end
		end
	end

	// memory addresses
	assign cor_base   = COR_AW'((32'(fan_q) * STAVE_TYPES + 32'(stype_q)) * ELEMS + 32'(elem_q));
	assign tap_raddr  = TAP_AW'(32'(cor_base) * TAPS + 32'(k_q));
	assign hist_raddr = {elem_q, ptr_q[elem_q] - k_q};
	assign new_ptr    = ptr_q[in_elem] + 1'b1;
	assign hist_waddr = {in_elem, new_ptr};
	assign tap_we     = accept && (op == OP_TAP) && (32'(index) < TAP_DEPTH);
	assign cor_we     = accept && (op == OP_COR) && (32'(index) < COR_DEPTH);
	assign hist_we    = accept && (op == OP_SAMPLE) && elem_ok;

	fbs_ram #(.W(SMP_W), .D(TAP_DEPTH)) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (TAP_AW'(index)),
		.wdata (load_re),
		.raddr (tap_raddr),
		.rdata (tap_rd)
	);

	fbs_ram #(.W(2 * SMP_W), .D(COR_DEPTH)) u_cor_ram (
		.clk   (clk),
		.we    (cor_we),
		.waddr (COR_AW'(index)),
		.wdata ({load_re, load_im}),
		.raddr (cor_base),
		.rdata (cor_rd)
	);

	fbs_ram #(.W(2 * SMP_W), .D(HIST_DEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata ({sample_re, sample_im}),
		.raddr (hist_raddr),
		.rdata (hist_rd)
	);

	// operand selection for the shared unit
	always_comb begin
		mac_ctrl.clear  = (state_q == S_FAN) && fan_en[fan_q];
		mac_ctrl.acc_en = iss_s1;
		mx_re = acc_re_q;
		mx_im = acc_im_q;
		my_re = $signed(cor_rd[2*SMP_W-1:SMP_W]);
		my_im = $signed(cor_rd[SMP_W-1:0]);
		case (state_q)
			S_TAP, S_DRAIN: begin
				mx_re = hv_s1 ? ACC_W'($signed(hist_rd[2*SMP_W-1:SMP_W])) : '0;
				mx_im = hv_s1 ? ACC_W'($signed(hist_rd[SMP_W-1:0])) : '0;
				my_re = $signed(tap_rd);
				my_im = $signed(tap_rd);
			end
			S_COR2: begin
				my_re = $signed(cor_rd[SMP_W-1:0]);
				my_im = $signed(cor_rd[2*SMP_W-1:SMP_W]);
			end
			default: begin
			end
		endcase
	end

	fbs_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.x_re     (mx_re),
		.x_im     (mx_im),
		.y_re     (my_re),
		.y_im     (my_im),
		.p_re_s1  (p_re_s1),
		.p_im_s1  (p_im_s1),
		.acc_re_q (acc_re_q),
		.acc_im_q (acc_im_q),
		.busy     (mac_busy)
	);

	// correction terms, arithmetic shift floors
	assign dre = (P_W + 1)'(p_re_s1) - (P_W + 1)'(p_im_s1);
	assign dim = (P_W + 1)'(p_re_s1) + (P_W + 1)'(p_im_s1);
	assign tim = T_W'(dim >>> 15);

	// saturating fan sum update
	assign nsum_re = (SUM_W + 1)'(sum_re_q[fan_q]) + (SUM_W + 1)'(tre_q);
	assign nsum_im = (SUM_W + 1)'(sum_im_q[fan_q]) + (SUM_W + 1)'(tim);
	always_comb begin
		sat_re = nsum_re[SUM_W-1:0];
		sat_im = nsum_im[SUM_W-1:0];
		if (nsum_re[SUM_W] != nsum_re[SUM_W-1]) begin
			sat_re = nsum_re[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		if (nsum_im[SUM_W] != nsum_im[SUM_W-1]) begin
			sat_im = nsum_im[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_mask_q <= 8'hff;
			taps_q     <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FAN_MASK: fan_mask_q <= cfg_data;
				REG_TAPS:     taps_q     <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// per element history pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < ELEMS; e++) begin
				ptr_q[e] <= '0;
				cnt_q[e] <= '0;
			end
		end else if (hist_we) begin
			ptr_q[in_elem] <= new_ptr;
			if (first_sample) begin
				cnt_q[in_elem] <= TAP_CNT_W'(1);
			end else if (32'(cnt_q[in_elem]) < TAPS) begin
				cnt_q[in_elem] <= cnt_q[in_elem] + 1'b1;
			end
		end
	end

	// tap read pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= 1'b0;
			hv_s1  <= 1'b0;
		end else begin
			iss_s1 <= (state_q == S_TAP);
			hv_s1  <= (TAP_CNT_W'(k_q) < cnt_q[elem_q]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_COR2) begin
			tre_q <= T_W'(dre >>> 15);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fan_q     <= '0;
			k_q       <= '0;
			n_q       <= '0;
			elem_q    <= '0;
			stype_q   <= '0;
			last_q    <= 1'b0;
			out_valid <= 1'b0;
			fan       <= '0;
			out_re    <= '0;
			out_im    <= '0;
			last      <= 1'b0;
			for (int f = 0; f < FANS; f++) begin
				sum_re_q[f] <= '0;
				sum_im_q[f] <= '0;
			end
		end else begin
			// a taken beat leaves unless the emit step loads the register
			if (out_valid && out_ready && !((state_q == S_EMIT) && out_room)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_SAMPLE)) begin
						elem_q  <= in_elem;
						stype_q <= 2'(32'(stave_type) % STAVE_TYPES);
						last_q  <= last_element;
						n_q     <= n_next;
						fan_q   <= '0;
						if (elem_ok) begin
							state_q <= S_FAN;
						end else if (last_element) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_FAN: begin
					k_q <= '0;
					if (fan_en[fan_q]) begin
						state_q <= (n_q == '0) ? S_COR1 : S_TAP;
					end else if (fan_last) begin
						fan_q   <= '0;
						state_q <= last_q ? S_EMIT : S_IDLE;
					end else begin
						fan_q <= fan_q + 1'b1;
					end
				end
				S_TAP: begin
					if (TAP_CNT_W'(k_q) == n_q - 1'b1) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!iss_s1 && !mac_busy) begin
						state_q <= S_COR1;
					end
				end
				S_COR1: state_q <= S_COR2;
				S_COR2: state_q <= S_COR3;
				S_COR3: begin
					sum_re_q[fan_q] <= sat_re;
					sum_im_q[fan_q] <= sat_im;
					if (fan_last) begin
						fan_q   <= '0;
						state_q <= last_q ? S_EMIT : S_IDLE;
					end else begin
						fan_q   <= fan_q + 1'b1;
						state_q <= S_FAN;
					end
				end
				S_EMIT: begin
					if (out_room) begin
						out_valid <= fan_en[fan_q];
						if (fan_en[fan_q]) begin
							fan       <= 3'(fan_q);
							out_re    <= sum_re_q[fan_q];
							out_im    <= sum_im_q[fan_q];
							last      <= !higher_en;
						end
						if (fan_last) begin
							fan_q   <= '0;
							state_q <= S_IDLE;
							for (int f = 0; f < FANS; f++) begin
								sum_re_q[f] <= '0;
								sum_im_q[f] <= '0;
							end
						end else begin
							fan_q <= fan_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no tap work outstanding when a new beat can be taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!iss_s1 && !mac_busy))
		else $error("tap pipeline busy while idle");

	// the tap walk never starts with a zero tap count
	a_tap_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAP) |-> (n_q != '0))
		else $error("tap walk with zero taps");

	// correction multiplies see a drained accumulator
	a_cor_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COR1) |-> (!iss_s1 && !mac_busy))
		else $error("correction started before accumulation drained");

endmodule
`default_nettype wire

/* hw/rtl/fbs_ram.sv */
`default_nettype none
module fbs_ram #(
	parameter int W = 16,
	parameter int D = 16
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                  wdata,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                  rdata
);
	logic [W-1:0] mem [D];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/fbs_mac.sv */
`default_nettype none
module fbs_mac (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire fbs_pkg::mac_ctrl_t                  ctrl,
	input  wire logic signed [fbs_pkg::ACC_W-1:0]    x_re,
	input  wire logic signed [fbs_pkg::ACC_W-1:0]    x_im,
	input  wire logic signed [fbs_pkg::SMP_W-1:0]    y_re,
	input  wire logic signed [fbs_pkg::SMP_W-1:0]    y_im,
	output logic signed      [fbs_pkg::P_W-1:0]      p_re_s1,
	output logic signed      [fbs_pkg::P_W-1:0]      p_im_s1,
	output logic signed      [fbs_pkg::ACC_W-1:0]    acc_re_q,
	output logic signed      [fbs_pkg::ACC_W-1:0]    acc_im_q,
	output logic                                     busy
);
	import fbs_pkg::*;

	logic acc_en_s1;

	// two registered multipliers
	always_ff @(posedge clk) begin
		p_re_s1 <= P_W'(x_re) * P_W'(y_re);
		p_im_s1 <= P_W'(x_im) * P_W'(y_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= ctrl.acc_en;
		end
	end

	// accumulators follow the product stage
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (acc_en_s1) begin
			acc_re_q <= acc_re_q + ACC_W'(p_re_s1);
			acc_im_q <= acc_im_q + ACC_W'(p_im_s1);
		end
	end

	assign busy = acc_en_s1;
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import fbs_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam longint SUM_MAX = 64'sd140737488355327;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam int DRAIN_CYCLES = 400;
	localparam int PHASE_ITEMS = 62;
	localparam int SAT_SAMPLES = 2100;

	typedef struct {
		logic [1:0]         op;
		logic [13:0]        index;
		logic [3:0]         element;
		logic [1:0]         stave_type;
		logic               first_sample;
		logic               last_element;
		logic signed [15:0] sample_re;
		logic signed [15:0] sample_im;
		logic signed [15:0] load_re;
		logic signed [15:0] load_im;
	} stave_beat_t;

	typedef struct {
		logic [2:0]         fan;
		logic signed [47:0] re;
		logic signed [47:0] im;
		logic               last;
	} fan_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [13:0] index = '0;
	logic [3:0] element = '0;
	logic [1:0] stave_type = '0;
	logic first_sample = 1'b0;
	logic last_element = 1'b0;
	logic signed [15:0] sample_re = '0;
	logic signed [15:0] sample_im = '0;
	logic signed [15:0] load_re = '0;
	logic signed [15:0] load_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] fan;
	logic signed [47:0] out_re;
	logic signed [47:0] out_im;
	logic last;

	fir_beamformer_stave_unit uut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// beamformer state mirror
	logic signed [15:0] tap_mem [TAP_DEPTH];
	logic signed [15:0] cor_re [COR_DEPTH];
	logic signed [15:0] cor_im [COR_DEPTH];
	logic signed [15:0] hist_re [ELEMS][TAPS];
	logic signed [15:0] hist_im [ELEMS][TAPS];
	longint beam_re [FANS];
	longint beam_im [FANS];
	logic [7:0] fan_mask_cfg = 8'hFF;
	logic [5:0] taps_cfg = 6'd32;

	// stimulus bookkeeping: entries loaded so far
	bit tap_seen [TAP_DEPTH];
	bit cor_seen [COR_DEPTH];

	stave_beat_t pending_q[$];
	fan_beat_t beam_q[$];
	stave_beat_t cur_beat;
	bit in_hold = 1'b0;
	bit idle_on = 1'b1;
	int in_gap = 0;
	int out_gap = 0;
	int mismatches = 0;
	int stim_items = 0;

	function automatic longint sat48(longint a);
		if (a > SUM_MAX) return SUM_MAX;
		if (a < SUM_MIN) return SUM_MIN;
		return a;
	endfunction

	// work out the fan beats caused by one accepted beat
	function automatic void beam_predict(stave_beat_t b);
		int n, base, cnt;
		longint ar, ai, cr, ci, tp;
		if (b.op == OP_TAP) begin
			if (b.index < TAP_DEPTH) tap_mem[b.index] = b.load_re;
			return;
		end
		if (b.op == OP_COR) begin
			if (b.index < COR_DEPTH) begin
				cor_re[b.index] = b.load_re;
				cor_im[b.index] = b.load_im;
			end
			return;
		end
		if (b.op != OP_SAMPLE) return;
		n = (taps_cfg > TAPS) ? TAPS : taps_cfg;
		// history shift, newest at slot 0
		if (b.first_sample) begin
			for (int k = 0; k < TAPS; k++) begin
				hist_re[b.element][k] = '0;
				hist_im[b.element][k] = '0;
			end
		end
		for (int k = TAPS - 1; k > 0; k--) begin
			hist_re[b.element][k] = hist_re[b.element][k-1];
			hist_im[b.element][k] = hist_im[b.element][k-1];
		end
		hist_re[b.element][0] = b.sample_re;
		hist_im[b.element][0] = b.sample_im;
		// fir, correction and fan accumulation
		for (int f = 0; f < FANS; f++) begin
			if (!fan_mask_cfg[f]) continue;
			base = (f * STAVE_TYPES + (b.stave_type % STAVE_TYPES)) * ELEMS + b.element;
			ar = 0;
			ai = 0;
			for (int k = 0; k < n; k++) begin
				tp = tap_mem[base * TAPS + k];
				ar += longint'(hist_re[b.element][k]) * tp;
				ai += longint'(hist_im[b.element][k]) * tp;
			end
			cr = cor_re[base];
			ci = cor_im[base];
			beam_re[f] = sat48(beam_re[f] + ((ar * cr - ai * ci) >>> 15));
			beam_im[f] = sat48(beam_im[f] + ((ar * ci + ai * cr) >>> 15));
		end
		// emit and clear on the last element
		if (b.last_element) begin
			cnt = 0;
			for (int f = 0; f < FANS; f++) begin
				if (!fan_mask_cfg[f]) continue;
				beam_q.push_back('{fan: f[2:0], re: beam_re[f][47:0],
					im: beam_im[f][47:0], last: 1'b0});
				cnt++;
			end
			if (cnt > 0) beam_q[beam_q.size()-1].last = 1'b1;
			for (int f = 0; f < FANS; f++) begin
				beam_re[f] = 0;
				beam_im[f] = 0;
			end
		end
	endfunction

	// input driver
	always @(negedge clk) begin
		if (arst_n && !in_hold) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				cur_beat = pending_q.pop_front();
				op <= cur_beat.op;
				index <= cur_beat.index;
				element <= cur_beat.element;
				stave_type <= cur_beat.stave_type;
				first_sample <= cur_beat.first_sample;
				last_element <= cur_beat.last_element;
				sample_re <= cur_beat.sample_re;
				sample_im <= cur_beat.sample_im;
				load_re <= cur_beat.load_re;
				load_im <= cur_beat.load_im;
				in_valid <= 1'b1;
				in_hold = 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 12);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// input beat accepted
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			beam_predict(cur_beat);
			in_hold = 1'b0;
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 12);
		end
	end

	// output checker
	always @(posedge clk) begin
		fan_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (beam_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: fan %0d re %0d im %0d last %0b",
						fan, out_re, out_im, last);
			end else begin
				want = beam_q.pop_front();
				if (fan !== want.fan || out_re !== want.re || out_im !== want.im
						|| last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp fan %0d re %0d im %0d last %0b, ",
							"got fan %0d re %0d im %0d last %0b"},
							want.fan, want.re, want.im, want.last,
							fan, out_re, out_im, last);
				end
			end
		end
	end

	function automatic logic signed [15:0] rand_s16();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic write_reg(logic idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_FAN_MASK) fan_mask_cfg = val;
		else taps_cfg = val[5:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || in_hold || beam_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_load(logic [1:0] o, int addr, logic signed [15:0] re,
			logic signed [15:0] im);
		stave_beat_t b;
		b = '{op: o, index: addr[13:0], element: 4'($urandom()),
			stave_type: 2'($urandom()), first_sample: 1'($urandom()),
			last_element: 1'($urandom()), sample_re: 16'($urandom()),
			sample_im: 16'($urandom()), load_re: re, load_im: im};
		if (o == OP_TAP && addr < TAP_DEPTH) tap_seen[addr] = 1'b1;
		if (o == OP_COR && addr < COR_DEPTH) cor_seen[addr] = 1'b1;
		pending_q.push_back(b);
	endtask

	// sample beat, preceded by loads of any coefficient it would read unloaded
	task automatic queue_sample(int e, int st, bit first, bit lastel,
			logic signed [15:0] re, logic signed [15:0] im);
		int n, base;
		stave_beat_t b;
		n = (taps_cfg > TAPS) ? TAPS : taps_cfg;
		for (int f = 0; f < FANS; f++) begin
			if (!fan_mask_cfg[f]) continue;
			base = (f * STAVE_TYPES + st) * ELEMS + e;
			if (!cor_seen[base]) queue_load(OP_COR, base, rand_s16(), rand_s16());
			for (int k = 0; k < n; k++)
				if (!tap_seen[base * TAPS + k])
					queue_load(OP_TAP, base * TAPS + k, rand_s16(), rand_s16());
		end
		b = '{op: OP_SAMPLE, index: 14'($urandom()), element: e[3:0], stave_type: st[1:0],
			first_sample: first, last_element: lastel, sample_re: re, sample_im: im,
			load_re: 16'($urandom()), load_im: 16'($urandom())};
		pending_q.push_back(b);
		stim_items++;
	endtask

	// stave sweeps over one to three sample times, over all elements or the first one to six
	task automatic stave_sweep();
		int times, nel, st;
		times = $urandom_range(1, 3);
		nel = ($urandom_range(0, 5) == 0) ? ELEMS : $urandom_range(1, 6);
		st = $urandom_range(0, STAVE_TYPES - 1);
		for (int t = 0; t < times; t++)
			for (int e = 0; e < nel; e++)
				queue_sample(e, st, t == 0, e == nel - 1, rand_s16(), rand_s16());
	endtask

	// loose beats: stray loads, spare op, unaligned samples
	task automatic noise_beat();
		stave_beat_t b;
		case ($urandom_range(0, 3))
			0: queue_load(OP_TAP, $urandom_range(0, TAP_DEPTH - 1), rand_s16(), rand_s16());
			1: queue_load(OP_COR, $urandom_range(0, 1023), rand_s16(), rand_s16());
			2: begin
				b = '{op: OP_SPARE, index: 14'($urandom()), element: 4'($urandom()),
					stave_type: 2'($urandom()), first_sample: 1'($urandom()),
					last_element: 1'($urandom()), sample_re: 16'($urandom()),
					sample_im: 16'($urandom()), load_re: 16'($urandom()),
					load_im: 16'($urandom())};
				pending_q.push_back(b);
			end
			default: queue_sample($urandom_range(0, ELEMS - 1),
				$urandom_range(0, STAVE_TYPES - 1), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), rand_s16(), rand_s16());
		endcase
		stim_items++;
	endtask

	// run time limit
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// stimulus sequence
	initial begin
		int sat_base;
		logic [7:0] mask_v;
		logic [7:0] taps_v;
		for (int f = 0; f < FANS; f++) begin
			beam_re[f] = 0;
			beam_im[f] = 0;
		end
		for (int e = 0; e < ELEMS; e++)
			for (int k = 0; k < TAPS; k++) begin
				hist_re[e][k] = '0;
				hist_im[e][k] = '0;
			end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: address extremes, spare op, sample extremes
		queue_load(OP_TAP, TAP_DEPTH - 1, 16'sh8000, 16'sh7FFF);
		queue_load(OP_TAP, 0, 16'sh7FFF, 16'sh8000);
		queue_load(OP_COR, COR_DEPTH - 1, 16'sh7FFF, 16'sh8000);
		queue_load(OP_COR, 16383, 16'sh1234, 16'sh4321);
		pending_q.push_back('{op: OP_SPARE, index: 14'h3FFF, element: 4'hF,
			stave_type: 2'd3, first_sample: 1'b1, last_element: 1'b1,
			sample_re: 16'sh7FFF, sample_im: 16'sh8000, load_re: 16'sh8000,
			load_im: 16'sh7FFF});
		queue_sample(ELEMS - 1, STAVE_TYPES - 1, 1'b1, 1'b0, 16'sh8000, 16'sh7FFF);
		queue_sample(0, 0, 1'b1, 1'b0, 16'sh7FFF, 16'sh8000);
		queue_sample(ELEMS - 1, STAVE_TYPES - 1, 1'b0, 1'b1, 16'sh8000, 16'sh8000);
		drain();

		// zero taps and no fans: last element emits nothing
		write_reg(REG_TAPS, 8'd0);
		write_reg(REG_FAN_MASK, 8'h00);
		queue_sample(3, 1, 1'b1, 1'b0, 16'sh7FFF, 16'sh7FFF);
		queue_sample(4, 1, 1'b0, 1'b1, 16'sh8000, 16'sh7FFF);
		drain();
		// tap count above range, top fan only
		write_reg(REG_TAPS, 8'd63);
		write_reg(REG_FAN_MASK, 8'h80);
		queue_sample(ELEMS - 1, 2, 1'b0, 1'b1, 16'sh7FFF, 16'sh8000);
		drain();
		write_reg(REG_TAPS, 8'd1);
		write_reg(REG_FAN_MASK, 8'h81);
		queue_sample(2, 3, 1'b0, 1'b1, 16'sh8000, 16'sh8000);
		drain();

		// saturation: full-scale taps, fan 0 imaginary runs negative, fan 1 real positive
		write_reg(REG_FAN_MASK, 8'h03);
		write_reg(REG_TAPS, 8'd32);
		for (int f = 0; f < 2; f++) begin
			sat_base = (f * STAVE_TYPES) * ELEMS;
			for (int k = 0; k < TAPS; k++)
				queue_load(OP_TAP, sat_base * TAPS + k, 16'sh8000, 16'sh0);
		end
		queue_load(OP_COR, 0, 16'sh8000, 16'sh8000);
		queue_load(OP_COR, STAVE_TYPES * ELEMS, 16'sh7FFF, 16'sh8000);
		for (int i = 0; i < SAT_SAMPLES; i++)
			queue_sample(0, 0, i == 0, i == SAT_SAMPLES - 1, 16'sh8000, 16'sh8000);
		drain();

		// random phases over several settings, the last without idling
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin mask_v = 8'hFF; taps_v = 8'd32; end
				1: begin mask_v = 8'($urandom()); taps_v = 8'd1; end
				2: begin mask_v = 8'($urandom()); taps_v = 8'($urandom_range(1, 32)); end
				3: begin mask_v = 8'h55; taps_v = 8'd63; end
				default: begin
					mask_v = 8'($urandom());
					taps_v = 8'($urandom_range(1, 32));
				end
			endcase
			write_reg(REG_FAN_MASK, mask_v);
			write_reg(REG_TAPS, taps_v);
			idle_on = (p < 4);
			stim_items = 0;
			while (stim_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0) noise_beat();
				else stave_sweep();
			end
			// close any open stave so the sums start clean
			queue_sample(0, 0, 1'b0, 1'b1, rand_s16(), rand_s16());
			drain();
		end

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
